FILE: sv/i2cbm_pkg.sv
// shared types and constants for the i2c bit-level master
// item structs, operation codes, sequencer phases, register map
// no dependencies
package i2cbm_pkg;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [0:0] REG_SLOT_TICKS = 1'b0;
    localparam logic [7:0] SLOT_TICKS_RESET = 8'd5;

    // operation codes carried by an input item
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP = 3'd2;
    localparam logic [2:0] OP_ACK = 3'd3;
    localparam logic [2:0] OP_NACK = 3'd4;
    localparam logic [2:0] OP_READ = 3'd5;
    localparam logic [2:0] OP_WRITE = 3'd6;
    localparam logic [2:0] OP_WRITE_CMD = 3'd7;

    localparam logic [7:0] MSB_MASK = 8'h80;

    // sequencer phases
    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_START   = 14'b00000000000010,
        PH_STOP    = 14'b00000000000100,
        PH_ACK     = 14'b00000000001000,
        PH_NACK    = 14'b00000000010000,
        PH_READ    = 14'b00000000100000,
        PH_WBIT    = 14'b00000001000000,
        PH_WACK    = 14'b00000010000000,
        PH_C_START = 14'b00000100000000,
        PH_C_DBIT  = 14'b00001000000000,
        PH_C_DACK  = 14'b00010000000000,
        PH_C_CBIT  = 14'b00100000000000,
        PH_C_CACK  = 14'b01000000000000,
        PH_C_STOP  = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic [7:0] second_byte;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] read_value;
        logic       read_done;
        logic       rejected;
    } out_item_t;

endpackage

FILE: sv/i2cbm_regs.sv
// apb configuration register file for the i2c bit-level master
// holds slot_ticks; depends on i2cbm_pkg
module i2cbm_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cbm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [i2cbm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [7:0]                          slot_ticks
);

    logic [7:0] slot_ticks_reg;
    logic       hit_slot;

    assign pready = 1'b1;
    assign hit_slot = (paddr[i2cbm_pkg::CFG_ADDR_W-1:2] == i2cbm_pkg::REG_SLOT_TICKS);

    // register write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ticks_reg <= i2cbm_pkg::SLOT_TICKS_RESET;
        end
        else if (psel && penable && pwrite && hit_slot)
        begin
            slot_ticks_reg <= pwdata[7:0];
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        if (hit_slot)
        begin
            prdata = {{(i2cbm_pkg::CFG_DATA_W-8){1'b0}}, slot_ticks_reg};
        end
    end

    assign slot_ticks = slot_ticks_reg;

endmodule

FILE: sv/i2cbm_core.sv
// sequencer state and per-tick step logic of the i2c bit-level master
// one step per accepted item; depends on i2cbm_pkg
module i2cbm_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  i2cbm_pkg::in_item_t    item,
    input  logic [7:0]             slot_ticks,
    output i2cbm_pkg::out_item_t   res
);

    i2cbm_pkg::phase_t phase_reg, phase_next;
    logic [2:0] slot_step_reg, slot_step_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [7:0] read_hold_reg, read_hold_next;

    logic [7:0] len_m1;
    logic       expire;
    logic       started;
    logic       done;
    logic       rej;
    logic [3:0] bc_inc;
    logic [1:0] levels;

    // levels set on the first tick of a slot, {scl, sda}
    function automatic logic [1:0] apply_slot(i2cbm_pkg::phase_t ph, logic [2:0] s,
                                              logic msb, logic scl, logic sda);
        logic c;
        logic d;
        c = scl;
        d = sda;
        case (ph)
            i2cbm_pkg::PH_START, i2cbm_pkg::PH_C_START:
            begin
                if (s == 3'd0) d = 1'b1;
                else if (s == 3'd1) c = 1'b1;
                else if (s == 3'd2) d = 1'b0;
                else c = 1'b0;
            end
            i2cbm_pkg::PH_STOP, i2cbm_pkg::PH_C_STOP:
            begin
                if (s == 3'd0) c = 1'b0;
                else if (s == 3'd1) d = 1'b0;
                else if (s == 3'd2) c = 1'b1;
                else d = 1'b1;
            end
            i2cbm_pkg::PH_ACK, i2cbm_pkg::PH_NACK:
            begin
                if (s == 3'd0) d = (ph == i2cbm_pkg::PH_NACK);
                else if (s == 3'd1) c = 1'b1;
                else c = 1'b0;
            end
            i2cbm_pkg::PH_READ:
            begin
                if (s == 3'd0)
                begin
                    c = 1'b0;
                    d = 1'b1;
                end
                else if (s == 3'd1) c = 1'b1;
                else if (s == 3'd3) c = 1'b0;
            end
            i2cbm_pkg::PH_WBIT, i2cbm_pkg::PH_C_DBIT, i2cbm_pkg::PH_C_CBIT:
            begin
                if (s == 3'd0) c = 1'b0;
                else if (s == 3'd1) d = msb;
                else if (s == 3'd3) c = 1'b1;
                else if (s == 3'd4) c = 1'b0;
            end
            i2cbm_pkg::PH_WACK, i2cbm_pkg::PH_C_DACK, i2cbm_pkg::PH_C_CACK:
            begin
                if (s == 3'd0) d = 1'b1;
                else if (s == 3'd2) c = 1'b1;
                else c = 1'b0;
            end
            default:
            begin
                c = scl;
            end
        endcase
        return {c, d};
    endfunction

    // slot length, zero acts as one
    assign len_m1 = (slot_ticks == 8'd0) ? 8'd0 : slot_ticks - 8'd1;
    assign expire = (tick_count_reg >= len_m1);
    assign bc_inc = bit_count_reg + 4'd1;

    // one tick of the sequencer
    always_comb
    begin
        phase_next      = phase_reg;
        slot_step_next  = slot_step_reg;
        bit_count_next  = bit_count_reg;
        shifter_next    = shifter_reg;
        pending_next    = pending_reg;
        tick_count_next = tick_count_reg;
        read_hold_next  = read_hold_reg;
        started         = 1'b0;
        done            = 1'b0;
        rej             = 1'b0;

        if (phase_reg == i2cbm_pkg::PH_IDLE)
        begin
            // command start
            if (item.operation != i2cbm_pkg::OP_TICK)
            begin
                started         = 1'b1;
                bit_count_next  = 4'd0;
                tick_count_next = 8'd0;
                slot_step_next  = 3'd0;
                case (item.operation)
                    i2cbm_pkg::OP_START:  phase_next = i2cbm_pkg::PH_START;
                    i2cbm_pkg::OP_STOP:   phase_next = i2cbm_pkg::PH_STOP;
                    i2cbm_pkg::OP_ACK:    phase_next = i2cbm_pkg::PH_ACK;
                    i2cbm_pkg::OP_NACK:   phase_next = i2cbm_pkg::PH_NACK;
                    i2cbm_pkg::OP_READ:
                    begin
                        phase_next   = i2cbm_pkg::PH_READ;
                        shifter_next = 8'd0;
                    end
                    i2cbm_pkg::OP_WRITE:
                    begin
                        phase_next   = i2cbm_pkg::PH_WBIT;
                        shifter_next = item.data_byte;
                    end
                    i2cbm_pkg::OP_WRITE_CMD:
                    begin
                        phase_next   = i2cbm_pkg::PH_C_START;
                        shifter_next = item.data_byte;
                        pending_next = item.second_byte;
                    end
                    default:   phase_next = i2cbm_pkg::PH_IDLE;
                endcase
            end
        end
        else
        begin
            rej = (item.operation != i2cbm_pkg::OP_TICK);
            if (!expire)
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end
            else
            begin
                // end of slot: advance the sequence
                tick_count_next = 8'd0;
                case (phase_reg)
                    i2cbm_pkg::PH_START, i2cbm_pkg::PH_C_START:
                    begin
                        if (slot_step_reg < 3'd3) slot_step_next = slot_step_reg + 3'd1;
                        else if (phase_reg == i2cbm_pkg::PH_START)
                        begin
                            phase_next     = i2cbm_pkg::PH_IDLE;
                            slot_step_next = 3'd0;
                        end
                        else
                        begin
                            bit_count_next = 4'd0;
                            phase_next     = i2cbm_pkg::PH_C_DBIT;
                            slot_step_next = 3'd0;
                        end
                    end
                    i2cbm_pkg::PH_STOP, i2cbm_pkg::PH_C_STOP:
                    begin
                        if (slot_step_reg < 3'd3) slot_step_next = slot_step_reg + 3'd1;
                        else
                        begin
                            phase_next     = i2cbm_pkg::PH_IDLE;
                            slot_step_next = 3'd0;
                        end
                    end
                    i2cbm_pkg::PH_ACK, i2cbm_pkg::PH_NACK:
                    begin
                        if (slot_step_reg < 3'd2) slot_step_next = slot_step_reg + 3'd1;
                        else
                        begin
                            phase_next     = i2cbm_pkg::PH_IDLE;
                            slot_step_next = 3'd0;
                        end
                    end
                    i2cbm_pkg::PH_READ:
                    begin
                        // sample at the end of the scl-high slot
                        if (slot_step_reg == 3'd1)
                        begin
                            shifter_next = {shifter_reg[6:0], item.sda_in};
                        end
                        if (slot_step_reg < 3'd3) slot_step_next = slot_step_reg + 3'd1;
                        else
                        begin
                            bit_count_next = bc_inc;
                            slot_step_next = 3'd0;
                            if (bc_inc[3])
                            begin
                                read_hold_next = shifter_reg;
                                done           = 1'b1;
                                phase_next     = i2cbm_pkg::PH_IDLE;
                            end
                        end
                    end
                    i2cbm_pkg::PH_WBIT, i2cbm_pkg::PH_C_DBIT, i2cbm_pkg::PH_C_CBIT:
                    begin
                        // a one bit skips the extra hold slot
                        if (slot_step_reg == 3'd1)
                        begin
                            slot_step_next = ((shifter_reg & i2cbm_pkg::MSB_MASK) != 8'd0)
                                             ? 3'd3 : 3'd2;
                        end
                        else if (slot_step_reg < 3'd4) slot_step_next = slot_step_reg + 3'd1;
                        else
                        begin
                            shifter_next   = {shifter_reg[6:0], 1'b0};
                            bit_count_next = bc_inc;
                            slot_step_next = 3'd0;
                            if (bc_inc[3])
                            begin
                                if (phase_reg == i2cbm_pkg::PH_WBIT)
                                    phase_next = i2cbm_pkg::PH_WACK;
                                else if (phase_reg == i2cbm_pkg::PH_C_DBIT)
                                    phase_next = i2cbm_pkg::PH_C_DACK;
                                else
                                    phase_next = i2cbm_pkg::PH_C_CACK;
                            end
                        end
                    end
                    i2cbm_pkg::PH_WACK, i2cbm_pkg::PH_C_DACK, i2cbm_pkg::PH_C_CACK:
                    begin
                        if (slot_step_reg < 3'd3) slot_step_next = slot_step_reg + 3'd1;
                        else
                        begin
                            slot_step_next = 3'd0;
                            if (phase_reg == i2cbm_pkg::PH_WACK)
                                phase_next = i2cbm_pkg::PH_IDLE;
                            else if (phase_reg == i2cbm_pkg::PH_C_DACK)
                            begin
                                shifter_next   = pending_reg;
                                bit_count_next = 4'd0;
                                phase_next     = i2cbm_pkg::PH_C_CBIT;
                            end
                            else
                                phase_next = i2cbm_pkg::PH_C_STOP;
                        end
                    end
                    default:
                    begin
                        phase_next     = i2cbm_pkg::PH_IDLE;
                        slot_step_next = 3'd0;
                    end
                endcase
            end
        end
    end

    // line levels for the slot being entered
    assign levels = apply_slot(phase_next, slot_step_next,
                               shifter_next[7], scl_reg, sda_reg);

    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        if ((started || expire) && (phase_next != i2cbm_pkg::PH_IDLE))
        begin
            scl_next = levels[1];
            sda_next = levels[0];
        end
    end

    // result of this tick
    always_comb
    begin
        res.scl_out    = scl_next;
        res.sda_out    = sda_next;
        res.busy_res   = (phase_next != i2cbm_pkg::PH_IDLE);
        res.read_value = read_hold_next;
        res.read_done  = done;
        res.rejected   = rej;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cbm_pkg::PH_IDLE;
            slot_step_reg  <= 3'd0;
            bit_count_reg  <= 4'd0;
            shifter_reg    <= 8'd0;
            pending_reg    <= 8'd0;
            tick_count_reg <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            read_hold_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            slot_step_reg  <= slot_step_next;
            bit_count_reg  <= bit_count_next;
            shifter_reg    <= shifter_next;
            pending_reg    <= pending_next;
            tick_count_reg <= tick_count_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            read_hold_reg  <= read_hold_next;
        end
    end

`ifndef SYNTHESIS
    // a read can only complete out of the read phase
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.read_done |-> phase_reg == i2cbm_pkg::PH_READ)
        else $error("read_done outside read phase");

    // rejection only happens while a sequence runs
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.rejected |-> phase_reg != i2cbm_pkg::PH_IDLE)
        else $error("command rejected while idle");

    // a byte never counts past eight bits
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit count overrun");

    // idle phase always holds slot step zero
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == i2cbm_pkg::PH_IDLE |-> slot_step_reg == 3'd0)
        else $error("idle with nonzero slot step");
`endif

endmodule

FILE: sv/i2c_bit_level_master.sv
// I2C bit-level master. Each input item is one tick of the bus timebase and
// yields exactly one result item with the SCL/SDA levels after that tick. An
// item is taken into an input register, stepped through the combinational
// sequencer and its result lands in an output register, so one item is
// accepted every clock cycle unless out_stall holds a full output register
// back; the sequencer step lies between those two registers. A command is
// started only on a tick where the master is idle, otherwise it is dropped
// and flagged rejected. slot_ticks (APB, byte address 0, reset 5) sets the
// ticks per waveform slot; 0 behaves as 1.
// Depends on i2cbm_pkg, i2cbm_regs and i2cbm_core.
module i2c_bit_level_master (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  i2cbm_pkg::in_item_t                 in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output i2cbm_pkg::out_item_t                out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cbm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [i2cbm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic                  in_valid_reg;
    i2cbm_pkg::in_item_t   in_item_reg;
    logic                  out_valid_reg;
    i2cbm_pkg::out_item_t  out_item_reg;
    logic                  fire;
    logic [7:0]            slot_ticks;
    i2cbm_pkg::out_item_t  step_res;

    // configuration registers
    i2cbm_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .slot_ticks (slot_ticks)
    );

    // step the held item when the output register is free or draining
    assign fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;

    i2cbm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (fire),
        .item       (in_item_reg),
        .slot_ticks (slot_ticks),
        .res        (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= in_item;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: dv/i2c_bit_level_master_tb.sv
// self-checking testbench for the i2c bit-level master
// predicts every result item from a cycle-level copy of the sequencer and slot_ticks
// depends on i2cbm_pkg and i2c_bit_level_master
module i2c_bit_level_master_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cbm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_ADDR_W-1:0] SLOT_TICKS_ADDR = CFG_ADDR_W'(4 * REG_SLOT_TICKS);

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // copy of the sequencer state used for prediction
    logic [7:0] slot_len_reg;
    phase_t     seq_phase;
    logic [2:0] slot_step;
    logic [3:0] bit_cnt;
    logic [7:0] shift_reg;
    logic [7:0] cmd_byte;
    logic [7:0] tick_cnt;
    logic       scl_lvl;
    logic       sda_lvl;
    logic [7:0] last_read;

    out_item_t  tick_results_q[$];
    int         error_count = 0;
    int         result_idx = 0;
    int         items_sent = 0;
    int         cycle_cnt = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    i2c_bit_level_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic reset_model();
        slot_len_reg = SLOT_TICKS_RESET;
        seq_phase = PH_IDLE;
        slot_step = '0;
        bit_cnt = '0;
        shift_reg = '0;
        cmd_byte = '0;
        tick_cnt = '0;
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        last_read = '0;
    endtask

    // line levels named by the first tick of the current slot
    task automatic set_levels();
        case (seq_phase)
            PH_START, PH_C_START:
                case (slot_step)
                    3'd0: sda_lvl = 1'b1;
                    3'd1: scl_lvl = 1'b1;
                    3'd2: sda_lvl = 1'b0;
                    default: scl_lvl = 1'b0;
                endcase
            PH_STOP, PH_C_STOP:
                case (slot_step)
                    3'd0: scl_lvl = 1'b0;
                    3'd1: sda_lvl = 1'b0;
                    3'd2: scl_lvl = 1'b1;
                    default: sda_lvl = 1'b1;
                endcase
            PH_ACK, PH_NACK:
                case (slot_step)
                    3'd0: sda_lvl = (seq_phase == PH_NACK);
                    3'd1: scl_lvl = 1'b1;
                    default: scl_lvl = 1'b0;
                endcase
            PH_READ:
                case (slot_step)
                    3'd0:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b1;
                    end
                    3'd1: scl_lvl = 1'b1;
                    3'd3: scl_lvl = 1'b0;
                    default: ;
                endcase
            PH_WBIT, PH_C_DBIT, PH_C_CBIT:
                case (slot_step)
                    3'd0: scl_lvl = 1'b0;
                    3'd1: sda_lvl = shift_reg[7];
                    3'd3: scl_lvl = 1'b1;
                    3'd4: scl_lvl = 1'b0;
                    default: ;
                endcase
            PH_WACK, PH_C_DACK, PH_C_CACK:
                case (slot_step)
                    3'd0: sda_lvl = 1'b1;
                    3'd2: scl_lvl = 1'b1;
                    default: scl_lvl = 1'b0;
                endcase
            default: ;
        endcase
    endtask

    // move on to the next slot once the current one has run out
    task automatic end_slot(input logic sda_bit, output logic read_end);
        read_end = 1'b0;
        case (seq_phase)
            PH_START, PH_C_START:
                if (slot_step < 3'd3)
                    slot_step++;
                else if (seq_phase == PH_START)
                    seq_phase = PH_IDLE;
                else
                begin
                    bit_cnt = '0;
                    seq_phase = PH_C_DBIT;
                    slot_step = '0;
                end
            PH_STOP, PH_C_STOP:
                if (slot_step < 3'd3)
                    slot_step++;
                else
                    seq_phase = PH_IDLE;
            PH_ACK, PH_NACK:
                if (slot_step < 3'd2)
                    slot_step++;
                else
                    seq_phase = PH_IDLE;
            PH_READ:
            begin
                if (slot_step == 3'd1)
                    shift_reg = {shift_reg[6:0], sda_bit};
                if (slot_step < 3'd3)
                    slot_step++;
                else
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    slot_step = '0;
                    if (bit_cnt >= 4'd8)
                    begin
                        last_read = shift_reg;
                        read_end = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                end
            end
            PH_WBIT, PH_C_DBIT, PH_C_CBIT:
                // a one bit skips the extra hold slot
                if (slot_step == 3'd1)
                    slot_step = shift_reg[7] ? 3'd3 : 3'd2;
                else if (slot_step < 3'd4)
                    slot_step++;
                else
                begin
                    shift_reg = {shift_reg[6:0], 1'b0};
                    bit_cnt = bit_cnt + 4'd1;
                    slot_step = '0;
                    if (bit_cnt >= 4'd8)
                    begin
                        if (seq_phase == PH_WBIT)
                            seq_phase = PH_WACK;
                        else if (seq_phase == PH_C_DBIT)
                            seq_phase = PH_C_DACK;
                        else
                            seq_phase = PH_C_CACK;
                    end
                end
            PH_WACK, PH_C_DACK, PH_C_CACK:
                if (slot_step < 3'd3)
                    slot_step++;
                else
                begin
                    slot_step = '0;
                    if (seq_phase == PH_WACK)
                        seq_phase = PH_IDLE;
                    else if (seq_phase == PH_C_DACK)
                    begin
                        shift_reg = cmd_byte;
                        bit_cnt = '0;
                        seq_phase = PH_C_CBIT;
                    end
                    else
                        seq_phase = PH_C_STOP;
                end
            default:
                seq_phase = PH_IDLE;
        endcase
        if (seq_phase == PH_IDLE)
            slot_step = '0;
    endtask

    // one bus tick: returns the result item the master must produce
    task automatic predict_tick(input in_item_t it, output out_item_t res);
        logic [7:0] len;
        logic       read_end;
        logic       dropped;
        len = (slot_len_reg == 8'd0) ? 8'd1 : slot_len_reg;
        read_end = 1'b0;
        dropped = 1'b0;
        if (seq_phase == PH_IDLE)
        begin
            if (it.operation != OP_TICK)
            begin
                bit_cnt = '0;
                tick_cnt = '0;
                slot_step = '0;
                case (it.operation)
                    OP_START: seq_phase = PH_START;
                    OP_STOP: seq_phase = PH_STOP;
                    OP_ACK: seq_phase = PH_ACK;
                    OP_NACK: seq_phase = PH_NACK;
                    OP_READ:
                    begin
                        shift_reg = '0;
                        seq_phase = PH_READ;
                    end
                    OP_WRITE:
                    begin
                        shift_reg = it.data_byte;
                        seq_phase = PH_WBIT;
                    end
                    default:
                    begin
                        shift_reg = it.data_byte;
                        cmd_byte = it.second_byte;
                        seq_phase = PH_C_START;
                    end
                endcase
                set_levels();
            end
        end
        else
        begin
            dropped = (it.operation != OP_TICK);
            if (tick_cnt + 9'd1 >= {1'b0, len})
            begin
                tick_cnt = '0;
                end_slot(it.sda_in, read_end);
                if (seq_phase != PH_IDLE)
                    set_levels();
            end
            else
                tick_cnt = tick_cnt + 8'd1;
        end
        res.scl_out = scl_lvl;
        res.sda_out = sda_lvl;
        res.busy_res = (seq_phase != PH_IDLE);
        res.read_value = last_read;
        res.read_done = read_end;
        res.rejected = dropped;
    endtask

    task automatic compare_field(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("mismatch, %s: expected %0h, got %0h", what, want_v, got_v);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        string     tag;
        result_idx++;
        if (tick_results_q.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d arrived with nothing expected: %p", result_idx, got);
        end
        else
        begin
            want = tick_results_q.pop_front();
            tag = $sformatf("result %0d", result_idx);
            compare_field({tag, " scl_out"}, 32'(want.scl_out), 32'(got.scl_out));
            compare_field({tag, " sda_out"}, 32'(want.sda_out), 32'(got.sda_out));
            compare_field({tag, " busy_res"}, 32'(want.busy_res), 32'(got.busy_res));
            compare_field({tag, " read_value"}, 32'(want.read_value), 32'(got.read_value));
            compare_field({tag, " read_done"}, 32'(want.read_done), 32'(got.read_done));
            compare_field({tag, " rejected"}, 32'(want.rejected), 32'(got.rejected));
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            check_result(out_item);
    end

    // send one item, with random sender gaps, and predict its result on acceptance
    task automatic send_item(input logic [2:0] op, input logic [7:0] d0, input logic [7:0] d1,
                             input logic sda);
        in_item_t  it;
        out_item_t want;
        it.operation = op;
        it.data_byte = d0;
        it.second_byte = d1;
        it.sda_in = sda;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_tick(it, want);
        tick_results_q.push_back(want);
        items_sent++;
    endtask

    // issue a command and keep ticking until the sequence is over
    task automatic run_command(input logic [2:0] op, input logic [7:0] d0, input logic [7:0] d1,
                               input int noise_pct, input int sda_pct);
        logic [2:0] busy_op;
        send_item(op, d0, d1, $urandom_range(99) < sda_pct);
        while (seq_phase != PH_IDLE)
        begin
            busy_op = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7, 1)) : OP_TICK;
            send_item(busy_op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      $urandom_range(99) < sda_pct);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= SLOT_TICKS_ADDR;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_slot_ticks();
        logic [31:0] rdata;
        apb_access(1'b0, '0, rdata);
        compare_field("slot_ticks readback", {24'd0, slot_len_reg}, rdata);
    endtask

    // change slot length only with the master idle and nothing in flight
    task automatic set_slot_ticks(input logic [7:0] ticks);
        logic [31:0] rdata;
        while (seq_phase != PH_IDLE)
            send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
        drain_results();
        apb_access(1'b1, {24'd0, ticks}, rdata);
        slot_len_reg = ticks;
        check_slot_ticks();
    endtask

    // reset slot length, idle ticks, start and stop at the default timing
    task automatic test_reset_state();
        check_slot_ticks();
        repeat (3) send_item(OP_TICK, 8'hFF, 8'hFF, 1'b1);
        send_item(OP_TICK, 8'h00, 8'h00, 1'b0);
        run_command(OP_START, 8'h00, 8'h00, 0, 50);
        run_command(OP_STOP, 8'hFF, 8'hFF, 0, 50);
    endtask

    // every command but start and stop, byte extremes, all-ones and all-zeros reads
    task automatic test_each_command();
        set_slot_ticks(8'd1);
        run_command(OP_ACK, 8'h00, 8'h00, 0, 50);
        run_command(OP_NACK, 8'h00, 8'h00, 0, 50);
        run_command(OP_READ, 8'h00, 8'h00, 0, 100);
        run_command(OP_READ, 8'h00, 8'h00, 0, 0);
        run_command(OP_READ, 8'h00, 8'h00, 0, 50);
        run_command(OP_WRITE, 8'h00, 8'h00, 0, 50);
        run_command(OP_WRITE, 8'hFF, 8'h00, 0, 50);
        run_command(OP_WRITE, 8'hA5, 8'h5A, 0, 50);
        run_command(OP_WRITE_CMD, 8'hFF, 8'h00, 0, 50);
        run_command(OP_WRITE_CMD, 8'h00, 8'hFF, 0, 50);
    endtask

    // commands on every busy tick, including the one that ends the sequence
    task automatic test_busy_reject();
        run_command(OP_START, 8'h00, 8'h00, 100, 50);
        run_command(OP_WRITE, 8'h3C, 8'h00, 100, 50);
    endtask

    // zero slot length acts as one, longest slot length, a short slot length
    task automatic test_slot_extremes();
        set_slot_ticks(8'd0);
        run_command(OP_READ, 8'h00, 8'h00, 0, 50);
        run_command(OP_WRITE_CMD, 8'h81, 8'h7E, 5, 50);
        set_slot_ticks(8'd255);
        run_command(OP_NACK, 8'h00, 8'h00, 2, 50);
        set_slot_ticks(8'd2);
        run_command(OP_WRITE, 8'h96, 8'h00, 0, 50);
    endtask

    // mostly complete commands with random content, some idle ticks and noisy sequences
    task automatic test_random_traffic(input logic [7:0] ticks, input int gaps, input int stalls,
                                       input int quota);
        int first_item;
        int pick;
        bit paused;
        set_slot_ticks(ticks);
        gap_pct = gaps;
        stall_pct = stalls;
        first_item = items_sent;
        paused = 1'b0;
        while (items_sent - first_item < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                run_command(3'($urandom_range(7, 1)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 6, 50);
            else if (pick < 92)
                repeat ($urandom_range(6, 1))
                    send_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                run_command(3'($urandom_range(7, 1)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 60, 50);
            // one full pause mid-phase with nothing outstanding
            if (!paused && items_sent - first_item >= quota / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reset_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_each_command();
        test_busy_reject();
        test_slot_extremes();
        test_random_traffic(8'd1, 0, 0, 100);
        test_random_traffic(8'd2, 54, 0, 100);
        test_random_traffic(8'd3, 0, 54, 100);
        test_random_traffic(8'd1, 11, 11, 100);

        drain_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
sv/i2cbm_pkg.sv
sv/i2cbm_regs.sv
sv/i2cbm_core.sv
sv/i2c_bit_level_master.sv
dv/i2c_bit_level_master_tb.sv
